[design/blzd_pkg.sv]
// Shared types, codes and constants of the backward LZ bitstream decoder.
`timescale 1ns / 1ps

package blzd_pkg;

    localparam logic KIND_BYTE  = 1'b0;
    localparam logic KIND_DRAIN = 1'b1;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_BAD_REF = 2'd1;
    localparam logic [1:0] ST_REFUSED = 2'd2;
    localparam logic [1:0] ST_DONE    = 2'd3;

    localparam logic [3:0]  BYTE_BITS   = 4'd8;
    localparam logic [3:0]  OFFSET_BITS = 4'd13;
    localparam logic [13:0] DIST_BIAS   = 14'd3;
    localparam logic [31:0] LEN_START   = 32'd3;
    localparam logic [7:0]  EXT_ESCAPE  = 8'hFF;
    localparam logic [2:0]  EXT_LEVEL   = 3'd4;

    typedef enum logic [5:0] {
        PH_FLAG    = 6'b000001,
        PH_LITERAL = 6'b000010,
        PH_OFFSET  = 6'b000100,
        PH_LEVEL   = 6'b001000,
        PH_EXT     = 6'b010000,
        PH_COPY    = 6'b100000
    } phase_t;

    typedef enum logic [2:0] {
        SQ_IDLE = 3'b001,
        SQ_BITS = 3'b010,
        SQ_COPY = 3'b100
    } seq_t;

    typedef struct packed {
        logic       kind;
        logic [7:0] data_byte;
    } item_t;

    typedef struct packed {
        logic [7:0]  out_byte;
        logic [31:0] bytes_before;
        logic        last;
        logic        copy_pending;
        logic [1:0]  status;
    } result_t;

    // Width of each length level field
    function automatic logic [3:0] level_width(input logic [1:0] lvl);
        logic [3:0] w;
        unique case (lvl)
            2'd0:    w = 4'd2;
            2'd1:    w = 4'd3;
            2'd2:    w = 4'd5;
            default: w = 4'd8;
        endcase
        return w;
    endfunction

endpackage

[design/backward_lz_bitstream_decoder.sv]
// Top level of the backward LZ bitstream decoder.
`timescale 1ns / 1ps

// Usage
// - Input channel (in_valid / in_stall, kind, data_byte): one transfer per item.
//   kind 0 carries the next compressed byte in consumption order (stream end
//   first, bits MSB first); kind 1 asks for the next byte of a pending match.
// - Output channel (out_valid / out_stall): one decoded byte per transfer with
//   its position, a last flag, a copy-pending flag and a status code.
// - Config: pulse cfg_wr_en with cfg_wr_data to set the output size; write it
//   only while the block is idle.
// - Timing: a two-entry queue takes input transfers while the decode engine is
//   busy and while a result sits in the output register. The engine takes an
//   item, then decodes one bit per cycle from the bit pool: a compressed byte
//   holds it at most while it consumes the leftover pool bits, its eight new ones
//   and a step to find the pool empty; a drain holds it for the byte it asks for.
//   A registered history read comes before each copied byte. Results appear in
//   the cycle after the deciding step.
// - Reset clears the decoder, the byte counter and the queue; the history
//   store is not cleared, since only bytes already written are ever read.
// - A stalled receiver holds the result register; the engine will not take a
//   new item until that register is free, and the queue then fills and stalls
//   the sender.
module backward_lz_bitstream_decoder #(
    parameter int HISTORY_DEPTH = 16384
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        kind,
    input  logic [7:0]  data_byte,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [7:0]  out_byte,
    output logic [31:0] bytes_before,
    output logic        last,
    output logic        copy_pending,
    output logic [1:0]  status,
    input  logic        cfg_wr_en,
    input  logic [31:0] cfg_wr_data
);

    logic [31:0]       size_reg, size_next;
    blzd_pkg::item_t   in_item;
    blzd_pkg::item_t   head;
    blzd_pkg::result_t res;
    logic              empty;
    logic              pop;

    assign in_item.kind      = kind;
    assign in_item.data_byte = data_byte;

    // Output size register
    assign size_next = cfg_wr_en ? cfg_wr_data : size_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            size_reg <= 32'd0;
        end
        else
        begin
            size_reg <= size_next;
        end
    end

    // Front: item queue
    blzd_fifo u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .in_item  (in_item),
        .pop      (pop),
        .empty    (empty),
        .head     (head)
    );

    // Back: decode engine with history and result register
    blzd_core #(
        .HISTORY_DEPTH (HISTORY_DEPTH)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .size      (size_reg),
        .empty     (empty),
        .head      (head),
        .pop       (pop),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .res       (res)
    );

    assign out_byte     = res.out_byte;
    assign bytes_before = res.bytes_before;
    assign last         = res.last;
    assign copy_pending = res.copy_pending;
    assign status       = res.status;

endmodule

[design/blzd_ram.sv]
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module blzd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16384
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

[design/blzd_fifo.sv]
// Front end: two-entry item queue that takes input transfers.
`timescale 1ns / 1ps

module blzd_fifo (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  blzd_pkg::item_t      in_item,
    input  logic                 pop,
    output logic                 empty,
    output blzd_pkg::item_t      head
);

    blzd_pkg::item_t slot_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] fill_reg, fill_next;
    logic       push;

    assign in_stall = (fill_reg == 2'd2);
    assign empty    = (fill_reg == 2'd0);
    assign head     = slot_reg[rd_ptr_reg];
    assign push     = in_valid && !in_stall;

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        fill_next   = fill_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= in_item;
        end
    end

endmodule

[design/blzd_core.sv]
// Back end: bit-serial decode sequencer, history store and result register.
`timescale 1ns / 1ps

module blzd_core #(
    parameter int HISTORY_DEPTH = 16384
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic [31:0]         size,
    input  logic                empty,
    input  blzd_pkg::item_t     head,
    output logic                pop,
    output logic                out_valid,
    input  logic                out_stall,
    output blzd_pkg::result_t   res
);

    localparam int AW = $clog2(HISTORY_DEPTH);

    blzd_pkg::seq_t   seq_reg, seq_next;
    blzd_pkg::phase_t phase_reg, phase_next;
    logic [7:0]  pool_reg, pool_next;
    logic [3:0]  left_reg, left_next;
    logic [7:0]  byte_reg, byte_next;
    logic        loaded_reg, loaded_next;
    logic [12:0] field_reg, field_next;
    logic [3:0]  taken_reg, taken_next;
    logic [2:0]  level_reg, level_next;
    logic [13:0] dist_reg, dist_next;
    logic [31:0] remain_reg, remain_next;
    logic [31:0] count_reg, count_next;
    logic        fin_reg, fin_next;
    logic [AW-1:0] wp_reg, wp_next;
    logic        out_valid_reg, out_valid_next;
    blzd_pkg::result_t res_reg, res_next;

    logic          out_free;
    logic          need_load;
    logic [7:0]    ep;
    logic [3:0]    el;
    logic          b;
    logic [12:0]   fv;
    logic [3:0]    ft;
    logic [3:0]    w;
    logic [32:0]   sum;
    logic          bad;
    logic          put_en;
    logic [7:0]    put_val;
    logic [1:0]    put_st;
    logic          last_hit;
    logic          ram_we;
    logic [7:0]    rdata;
    logic [AW:0]   wp_ext;
    logic [AW:0]   d_ext;
    logic [AW:0]   rd_full;
    logic [AW-1:0] raddr;

    assign out_free  = !out_valid_reg || !out_stall;
    assign out_valid = out_valid_reg;
    assign res       = res_reg;

    // Copy source: write pointer minus distance, wrapped round the store
    always_comb
    begin
        wp_ext  = {1'b0, wp_reg};
        d_ext   = (AW+1)'(dist_reg);
        rd_full = (wp_ext >= d_ext) ? (wp_ext - d_ext)
                                    : (wp_ext + (AW+1)'(HISTORY_DEPTH) - d_ext);
        raddr   = rd_full[AW-1:0];
    end

    blzd_ram #(
        .WIDTH (8),
        .DEPTH (HISTORY_DEPTH)
    ) u_hist (
        .clk   (clk),
        .we    (ram_we),
        .waddr (wp_reg),
        .wdata (put_val),
        .raddr (raddr),
        .rdata (rdata)
    );

    always_comb
    begin
        seq_next    = seq_reg;
        phase_next  = phase_reg;
        pool_next   = pool_reg;
        left_next   = left_reg;
        byte_next   = byte_reg;
        loaded_next = loaded_reg;
        field_next  = field_reg;
        taken_next  = taken_reg;
        level_next  = level_reg;
        dist_next   = dist_reg;
        remain_next = remain_reg;
        count_next  = count_reg;
        fin_next    = fin_reg;
        wp_next     = wp_reg;
        res_next    = res_reg;
        out_valid_next = out_valid_reg && out_stall;
        pop       = 1'b0;
        need_load = (left_reg == 4'd0) || (left_reg > 4'd8);
        ep        = need_load ? byte_reg : pool_reg;
        el        = need_load ? 4'd8 : left_reg;
        b         = ep[3'(el - 4'd1)];
        fv        = {field_reg[11:0], b};
        ft        = taken_reg + 4'd1;
        w         = blzd_pkg::level_width(level_reg[1:0]);
        sum       = 33'd0;
        bad       = (dist_reg == 14'd0) || ({18'd0, dist_reg} > count_reg);
        put_en    = 1'b0;
        put_val   = 8'd0;
        put_st    = blzd_pkg::ST_OK;
        last_hit  = 1'b0;
        ram_we    = 1'b0;

        unique case (seq_reg)
            blzd_pkg::SQ_IDLE:
            begin
                if (!empty && out_free)
                begin
                    pop = 1'b1;
                    if (fin_reg || count_reg >= size)
                    begin
                        out_valid_next = 1'b1;
                        res_next = '{8'd0, count_reg, 1'b0, 1'b0, blzd_pkg::ST_DONE};
                    end
                    else if (head.kind == blzd_pkg::KIND_DRAIN)
                    begin
                        // drain with nothing pending is dropped silently
                        if (phase_reg == blzd_pkg::PH_COPY)
                        begin
                            seq_next = blzd_pkg::SQ_COPY;
                        end
                    end
                    else if (phase_reg == blzd_pkg::PH_COPY)
                    begin
                        out_valid_next = 1'b1;
                        res_next = '{8'd0, count_reg, 1'b0, 1'b1, blzd_pkg::ST_REFUSED};
                    end
                    else
                    begin
                        byte_next   = head.data_byte;
                        loaded_next = 1'b0;
                        seq_next    = blzd_pkg::SQ_BITS;
                    end
                end
            end

            blzd_pkg::SQ_BITS:
            begin
                if (need_load && loaded_reg)
                begin
                    seq_next = blzd_pkg::SQ_IDLE;
                end
                else
                begin
                    if (need_load)
                    begin
                        loaded_next = 1'b1;
                    end
                    pool_next  = ep;
                    left_next  = el - 4'd1;
                    field_next = fv;
                    taken_next = ft;
                    unique case (phase_reg)
                        blzd_pkg::PH_FLAG:
                        begin
                            phase_next = b ? blzd_pkg::PH_OFFSET : blzd_pkg::PH_LITERAL;
                            field_next = 13'd0;
                            taken_next = 4'd0;
                        end
                        blzd_pkg::PH_LITERAL:
                        begin
                            if (ft >= blzd_pkg::BYTE_BITS)
                            begin
                                phase_next = blzd_pkg::PH_FLAG;
                                field_next = 13'd0;
                                taken_next = 4'd0;
                                put_en     = 1'b1;
                                put_val    = fv[7:0];
                                seq_next   = blzd_pkg::SQ_IDLE;
                            end
                        end
                        blzd_pkg::PH_OFFSET:
                        begin
                            if (ft >= blzd_pkg::OFFSET_BITS)
                            begin
                                dist_next   = {1'b0, fv} + blzd_pkg::DIST_BIAS;
                                remain_next = blzd_pkg::LEN_START;
                                level_next  = 3'd0;
                                phase_next  = blzd_pkg::PH_LEVEL;
                                field_next  = 13'd0;
                                taken_next  = 4'd0;
                            end
                        end
                        blzd_pkg::PH_LEVEL:
                        begin
                            if (ft >= w)
                            begin
                                sum = {1'b0, remain_reg} + 33'(fv);
                                remain_next = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
                                field_next  = 13'd0;
                                taken_next  = 4'd0;
                                if (fv == (13'd1 << w) - 13'd1)
                                begin
                                    level_next = level_reg + 3'd1;
                                    phase_next = (level_next >= blzd_pkg::EXT_LEVEL)
                                                 ? blzd_pkg::PH_EXT : blzd_pkg::PH_LEVEL;
                                end
                                else
                                begin
                                    phase_next = blzd_pkg::PH_COPY;
                                    seq_next   = blzd_pkg::SQ_COPY;
                                end
                            end
                        end
                        blzd_pkg::PH_EXT:
                        begin
                            if (ft >= blzd_pkg::BYTE_BITS)
                            begin
                                sum = {1'b0, remain_reg} + 33'(fv[7:0]);
                                remain_next = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
                                field_next  = 13'd0;
                                taken_next  = 4'd0;
                                if (fv[7:0] != blzd_pkg::EXT_ESCAPE)
                                begin
                                    phase_next = blzd_pkg::PH_COPY;
                                    seq_next   = blzd_pkg::SQ_COPY;
                                end
                            end
                        end
                        default:
                        begin
                            phase_next = blzd_pkg::PH_FLAG;
                        end
                    endcase
                end
            end

            blzd_pkg::SQ_COPY:
            begin
                // history read was launched in the previous cycle
                remain_next = (remain_reg != 32'd0) ? remain_reg - 32'd1 : 32'd0;
                if (remain_next == 32'd0)
                begin
                    phase_next = blzd_pkg::PH_FLAG;
                end
                put_en   = 1'b1;
                put_val  = bad ? 8'd0 : rdata;
                put_st   = bad ? blzd_pkg::ST_BAD_REF : blzd_pkg::ST_OK;
                seq_next = blzd_pkg::SQ_IDLE;
            end

            default:
            begin
                seq_next = blzd_pkg::SQ_IDLE;
            end
        endcase

        // Commit one decoded byte: store, count, check size
        if (put_en)
        begin
            ram_we     = 1'b1;
            count_next = count_reg + 32'd1;
            wp_next    = (wp_reg == AW'(HISTORY_DEPTH - 1)) ? '0 : wp_reg + AW'(1);
            last_hit   = (count_next >= size);
            if (last_hit)
            begin
                fin_next    = 1'b1;
                remain_next = 32'd0;
                phase_next  = blzd_pkg::PH_FLAG;
                left_next   = 4'd0;
            end
            out_valid_next = 1'b1;
            res_next = '{put_val, count_reg, last_hit,
                         (phase_next == blzd_pkg::PH_COPY) && (remain_next != 32'd0),
                         put_st};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seq_reg       <= blzd_pkg::SQ_IDLE;
            phase_reg     <= blzd_pkg::PH_FLAG;
            pool_reg      <= 8'd0;
            left_reg      <= 4'd0;
            loaded_reg    <= 1'b0;
            field_reg     <= 13'd0;
            taken_reg     <= 4'd0;
            level_reg     <= 3'd0;
            dist_reg      <= 14'd0;
            remain_reg    <= 32'd0;
            count_reg     <= 32'd0;
            fin_reg       <= 1'b0;
            wp_reg        <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            seq_reg       <= seq_next;
            phase_reg     <= phase_next;
            pool_reg      <= pool_next;
            left_reg      <= left_next;
            loaded_reg    <= loaded_next;
            field_reg     <= field_next;
            taken_reg     <= taken_next;
            level_reg     <= level_next;
            dist_reg      <= dist_next;
            remain_reg    <= remain_next;
            count_reg     <= count_next;
            fin_reg       <= fin_next;
            wp_reg        <= wp_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        byte_reg <= byte_next;
        res_reg  <= res_next;
    end

endmodule

[design/blzd_checker.sv]
// Port-level checks on the decoder, bound to the top level.
`timescale 1ns / 1ps

module blzd_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_stall,
    input logic [7:0]  out_byte,
    input logic [31:0] bytes_before,
    input logic        last,
    input logic        copy_pending,
    input logic [1:0]  status
);

    a_done_flags: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == blzd_pkg::ST_DONE |-> !last && !copy_pending)
        else $error("done result carries last or pending");

    a_refused_flags: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == blzd_pkg::ST_REFUSED |-> copy_pending && !last)
        else $error("refused byte without pending copy");

    a_last_ends_copy: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && last |-> !copy_pending)
        else $error("last byte still shows a pending copy");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(bytes_before) && $stable(out_byte))
        else $error("stalled result changed");

endmodule

bind backward_lz_bitstream_decoder blzd_checker u_chk (
    .clk          (clk),
    .rst_n        (rst_n),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_byte     (out_byte),
    .bytes_before (bytes_before),
    .last         (last),
    .copy_pending (copy_pending),
    .status       (status)
);
